[rtl/core/rpcs_pkg.sv]
// ----------------------------------------------------------------------------
// Receipt printer command stripper package
// Byte codes, queue sizing and the queue entry shared by the front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcs_pkg;

   // Control and printable byte codes of the print stream.
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_BELL     = 8'h07;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_SO       = 8'h0E;
   localparam logic [7:0] BYTE_DC4      = 8'h14;
   localparam logic [7:0] BYTE_ESC      = 8'h1B;
   localparam logic [7:0] BYTE_FS       = 8'h1C;
   localparam logic [7:0] BYTE_GS       = 8'h1D;
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] BYTE_BANG     = 8'h21;
   localparam logic [7:0] BYTE_MINUS    = 8'h2D;
   localparam logic [7:0] BYTE_SLASH    = 8'h2F;
   localparam logic [7:0] BYTE_UPPER_E  = 8'h45;
   localparam logic [7:0] BYTE_UPPER_F  = 8'h46;
   localparam logic [7:0] BYTE_UPPER_M  = 8'h4D;
   localparam logic [7:0] BYTE_UPPER_P  = 8'h50;
   localparam logic [7:0] BYTE_UPPER_V  = 8'h56;
   localparam logic [7:0] BYTE_LOWER_D  = 8'h64;
   localparam logic [7:0] BYTE_LOWER_R  = 8'h72;
   localparam logic [7:0] BYTE_DEL      = 8'h7F;
   localparam logic [7:0] BYTE_BOX_DASH = 8'hC4;

   // Number of entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // One classified input byte: one or two characters, or a bare end marker.
   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       first_valid;
      logic       pair;
      logic       ticket_end;
   } entry_type;

endpackage

`default_nettype wire

[rtl/core/rpcs_front.sv]
// ----------------------------------------------------------------------------
// Receipt printer command stripper front end
// Accepts bytes, tracks the command parse mode and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcs_front
   import rpcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // in_byte [7:0]
   input  wire logic       req_tlast,   // last_byte
   input  wire logic       q_full,
   output logic            push_valid,
   output entry_type       push_entry
);

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_GS,
      MODE_SKIP,
      MODE_AFTER_CR,
      MODE_AFTER_LF,
      MODE_BANG
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       emit;
      logic [7:0] char_out;
   } plain_type;

   mode_type   mode_ff, mode_in;
   logic [1:0] skip_ff, skip_in;

   // Handling of a byte outside any command context.
   function automatic plain_type plain_byte(input logic [7:0] b);
      plain_type res;
      res.mode     = MODE_NORMAL;
      res.emit     = 1'b0;
      res.char_out = b;
      if (b == BYTE_ESC) begin
         res.mode = MODE_ESC;
      end else if (b == BYTE_DC4 || b == BYTE_SO) begin
         res.emit = 1'b0;
      end else if (b == BYTE_GS) begin
         res.mode = MODE_GS;
      end else if (b == BYTE_CR) begin
         res.emit     = 1'b1;
         res.char_out = BYTE_CR;
         res.mode     = MODE_AFTER_CR;
      end else if (b == BYTE_LF) begin
         res.emit     = 1'b1;
         res.char_out = BYTE_CR;
         res.mode     = MODE_AFTER_LF;
      end else if (b == BYTE_BOX_DASH) begin
         res.emit     = 1'b1;
         res.char_out = BYTE_MINUS;
      end else if (b == BYTE_BANG) begin
         res.mode = MODE_BANG;
      end else if (b >= BYTE_SPACE && b <= BYTE_DEL) begin
         res.emit = 1'b1;
      end
      return res;
   endfunction

   logic       accept;
   plain_type  plain;
   logic       use_plain;
   logic       bang_emit;
   logic [1:0] n_chars;
   logic [7:0] char0, char1;
   logic [1:0] skip_dec;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign plain      = plain_byte(req_tdata);
   assign skip_dec   = (skip_ff != 2'd0) ? skip_ff - 2'd1 : skip_ff;

   // Next parse mode and the characters this byte produces.
   always_comb begin
      mode_in   = mode_ff;
      skip_in   = skip_ff;
      use_plain = 1'b0;
      bang_emit = 1'b0;
      case (mode_ff)
         MODE_ESC: begin
            if (req_tdata == BYTE_FS || req_tdata == BYTE_LOWER_R ||
                req_tdata == BYTE_LOWER_D || req_tdata == BYTE_MINUS) begin
               mode_in = MODE_SKIP;
               skip_in = 2'd1;
            end else if (req_tdata == BYTE_BELL) begin
               mode_in = MODE_SKIP;
               skip_in = 2'd3;
            end else if (req_tdata == BYTE_DC4 || req_tdata == BYTE_SO ||
                         req_tdata == BYTE_UPPER_P || req_tdata == BYTE_UPPER_M ||
                         req_tdata == BYTE_UPPER_F || req_tdata == BYTE_UPPER_E) begin
               mode_in = MODE_NORMAL;
            end else begin
               use_plain = 1'b1;
            end
         end
         MODE_GS: begin
            if (req_tdata == BYTE_UPPER_V || req_tdata == BYTE_SLASH) begin
               mode_in = MODE_SKIP;
               skip_in = 2'd1;
            end else begin
               use_plain = 1'b1;
            end
         end
         MODE_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 2'd0) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_AFTER_CR: begin
            if (req_tdata == BYTE_LF) begin
               mode_in = MODE_NORMAL;
            end else begin
               use_plain = 1'b1;
            end
         end
         MODE_AFTER_LF: begin
            if (req_tdata == BYTE_CR) begin
               mode_in = MODE_NORMAL;
            end else begin
               use_plain = 1'b1;
            end
         end
         MODE_BANG: begin
            if (req_tdata == BYTE_NUL) begin
               mode_in = MODE_NORMAL;
            end else begin
               bang_emit = 1'b1;
               use_plain = 1'b1;
            end
         end
         default: begin
            use_plain = 1'b1;
         end
      endcase
      if (use_plain) begin
         mode_in = plain.mode;
      end

      // Collect up to two characters in order.
      n_chars = 2'd0;
      char0   = BYTE_NUL;
      char1   = BYTE_NUL;
      if (bang_emit) begin
         char0   = BYTE_BANG;
         n_chars = 2'd1;
      end
      if (use_plain && plain.emit) begin
         if (n_chars == 2'd0) begin
            char0 = plain.char_out;
         end else begin
            char1 = plain.char_out;
         end
         n_chars = n_chars + 2'd1;
      end

      // Ticket end flushes a held '!' and returns to the reset state.
      if (req_tlast) begin
         if (mode_in == MODE_BANG) begin
            if (n_chars == 2'd0) begin
               char0 = BYTE_BANG;
            end else begin
               char1 = BYTE_BANG;
            end
            n_chars = n_chars + 2'd1;
         end
         mode_in = MODE_NORMAL;
         skip_in = 2'd0;
      end
   end

   // Queue entry for the back end.
   always_comb begin
      push_entry.first_char  = char0;
      push_entry.second_char = char1;
      push_entry.first_valid = (n_chars != 2'd0);
      push_entry.pair        = (n_chars == 2'd2);
      push_entry.ticket_end  = req_tlast;
      push_valid             = accept && ((n_chars != 2'd0) || req_tlast);
   end

   // Parse state advances on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         skip_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         skip_ff <= skip_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rpcs_queue.sv]
// ----------------------------------------------------------------------------
// Receipt printer command stripper queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcs_queue
   import rpcs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rpcs_back.sv]
// ----------------------------------------------------------------------------
// Receipt printer command stripper back end
// Splits queue entries into single characters and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcs_back
   import rpcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire entry_type  head_entry,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_char [7:0]
   output logic            rsp_tuser,   // char_valid
   output logic            rsp_tlast    // ticket_end
);

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic [7:0] data_ff, data_in;
   logic       user_ff, user_in;
   logic       last_ff, last_in;
   logic       load;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   // Load the output register when it is empty or being taken.
   assign load = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      pop       = 1'b0;
      valid_in  = valid_ff && !rsp_tready;
      second_in = second_ff;
      data_in   = data_ff;
      user_in   = user_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = 1'b1;
         user_in  = head_entry.first_valid;
         if (head_entry.pair && !second_ff) begin
            // First of two characters; the entry stays in the queue.
            data_in   = head_entry.first_char;
            last_in   = 1'b0;
            second_in = 1'b1;
         end else begin
            data_in   = second_ff ? head_entry.second_char : head_entry.first_char;
            last_in   = head_entry.ticket_end;
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Output payload needs no reset.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

[rtl/core/receipt_printer_command_stripper.sv]
// A byte's first character passes through the entry queue and then the output
// register of the back end before it is offered as a result transaction. The front
// takes one byte per cycle while the entry queue has room; a byte that yields two
// characters leaves as two transactions from the single output register.
// The front stalls only when the entry queue between front and back is full.
// Reset (synchronous, active high) returns to normal text mode and empties the
// queue and the output register.
// ----------------------------------------------------------------------------
// Receipt printer command stripper
// Strips printer command sequences from a receipt byte stream, leaving text.
// ----------------------------------------------------------------------------
`default_nettype none

module receipt_printer_command_stripper
   import rpcs_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // in_byte [7:0]
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_char [7:0]
   output logic            rsp_tuser,   // char_valid
   output logic            rsp_tlast    // ticket_end
);

   logic      q_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // Byte classification and parse state.
   rpcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Entry queue.
   rpcs_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Character output.
   rpcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/core/rpcs_checker.sv]
// ----------------------------------------------------------------------------
// Receipt printer command stripper checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A bare end marker carries a zero character and closes the ticket.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'h00))
      else $error("malformed bare end marker");

   // Every character is a CR or lies in the printable range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata == 8'h0D || (rsp_tdata >= 8'h20 && rsp_tdata <= 8'h7F)))
      else $error("character outside the text set");

   // A stalled transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled transaction changed");

endmodule

bind receipt_printer_command_stripper rpcs_checker u_rpcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
